// File: rtl/kwctf_pkg.sv
// shared types and constants for the keyed wait counter trace filter
`default_nettype none

package kwctf_pkg;

    // table geometry
    localparam int TABLE_DEPTH_DEF = 64;

    // stream payload widths
    localparam int WORD_W     = 32;
    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 160;
    localparam int TUSER_W    = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // event opcodes, also used as reported event kind
    localparam logic [TUSER_W-1:0] OP_SIGNAL    = 2'd0;
    localparam logic [TUSER_W-1:0] OP_BROADCAST = 2'd1;
    localparam logic [TUSER_W-1:0] OP_WAIT      = 2'd2;
    localparam logic [TUSER_W-1:0] OP_OTHER     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EARLY_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SHIFT = 8'd1;

    // configuration reset values
    localparam logic [7:0] EARLY_LIMIT_RST  = 8'd8;
    localparam logic [4:0] SAMPLE_SHIFT_RST = 5'd6;

    // one table slot
    typedef struct packed {
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] cond;
        logic [WORD_W-1:0] thread;
    } entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/keyed_wait_counter_trace_filter_unit.sv
// Keyed wait counter trace filter: condition-variable events in, trace reports out.
//
// Input stream s_*: one beat per event, opcode in s_tuser, addresses in s_tdata.
// Output stream m_*: at most one report beat per event, kind in m_tuser.
// Config channel cfg_*: index 0 early_limit, index 1 sample_shift; always ready,
// to be written only while the block is idle.
// Signal and broadcast beats go from idle to the emit state, which loads the
// report into the output register; the block then returns to idle for the next beat.
// A wait runs a scan of the slot table, one slot per cycle through a single
// comparator and incrementer on the table's registered read port, followed by a
// write-back state; the scan covers every slot when no match is found and ends
// early on a match. An "other" beat is dropped at once.
// s_tready is low while an event is being worked on.
// After reset the block clears the table, one slot per cycle, with s_tready
// low; config writes are taken during that pass.
// The report sits in an output register: the next event may be accepted while
// it waits, and if the receiver stalls the sequencer holds before emitting the
// following report until the register is free.
`default_nettype none

module keyed_wait_counter_trace_filter_unit #(
    parameter int TABLE_DEPTH = kwctf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata from bit 0: thread, cond_addr, mutex_addr, return_addr
    input  wire logic [kwctf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [kwctf_pkg::TUSER_W-1:0]     s_tuser,  // opcode
    // master side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata from bit 0: report_thread, report_cond, report_mutex,
    // report_return, wait_count
    output logic [kwctf_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [kwctf_pkg::TUSER_W-1:0]          m_tuser,  // event_kind
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kwctf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kwctf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kwctf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [CW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                have_free_reg, have_free_next;
    logic [AW-1:0]       free_idx_reg, free_idx_next;
    logic                hit_reg, hit_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    logic [TUSER_W-1:0]  op_reg, op_next;
    logic [WORD_W-1:0]   th_reg, th_next;
    logic [WORD_W-1:0]   cv_reg, cv_next;
    logic [WORD_W-1:0]   mx_reg, mx_next;
    logic [WORD_W-1:0]   ra_reg, ra_next;
    logic [WORD_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]          early_reg, early_next;
    logic [4:0]          shift_reg, shift_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    entry_t              rd_data;

    logic                slot_match;
    logic                report_ok;
    logic                out_free;
    logic [WORD_W-1:0]   sample_mask;

    // slot table
    kwctf_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // scan read issue
    assign rd_en   = (state_reg == ST_SCAN) && (issue_cnt_reg < CW'(TABLE_DEPTH));
    assign rd_addr = issue_cnt_reg[AW-1:0];

    // shared compare on the slot coming out of the table
    assign slot_match = (rd_data.thread == th_reg) && (rd_data.cond == cv_reg);

    // report filter for waits
    assign sample_mask = ~({WORD_W{1'b1}} << shift_reg);
    assign report_ok   = (cnt_reg <= {{(WORD_W-8){1'b0}}, early_reg})
                      || ((cnt_reg & sample_mask) == '0);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // sequencer next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        op_next        = op_reg;
        th_next        = th_reg;
        cv_next        = cv_reg;
        mx_next        = mx_reg;
        ra_next        = ra_reg;
        cnt_next       = cnt_reg;
        early_next     = early_reg;
        shift_next     = shift_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_addr_reg;
        wr_data        = '0;

        // output beat taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // config writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EARLY_LIMIT:  early_next = cfg_data[7:0];
                CFG_SAMPLE_SHIFT: shift_next = cfg_data[4:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = s_tuser;
                    th_next = s_tdata[31:0];
                    cv_next = s_tdata[63:32];
                    mx_next = s_tdata[95:64];
                    ra_next = s_tdata[127:96];
                    priority if (s_tuser == OP_OTHER)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (s_tuser == OP_WAIT)
                    begin
                        issue_cnt_next = '0;
                        cmp_valid_next = 1'b0;
                        have_free_next = 1'b0;
                        hit_next       = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cnt_next   = 32'd1;
                        mx_next    = '0;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                cmp_valid_next = rd_en;
                cmp_idx_next   = rd_addr;
                if (cmp_valid_reg)
                begin
                    if (slot_match)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        cnt_next     = rd_data.count + 32'd1;
                        state_next   = ST_UPDATE;
                    end
                    else
                    begin
                        if (!have_free_reg && (rd_data.thread == '0))
                        begin
                            have_free_next = 1'b1;
                            free_idx_next  = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_next = ST_UPDATE;
                        end
                    end
                end
            end

            ST_UPDATE:
            begin
                priority if (hit_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = hit_idx_reg;
                    wr_data = '{count: cnt_reg, cond: cv_reg, thread: th_reg};
                end
                else if (have_free_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = free_idx_reg;
                    wr_data  = '{count: 32'd1, cond: cv_reg, thread: th_reg};
                    cnt_next = 32'd1;
                end
                else
                begin
                    cnt_next = 32'd1;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    if ((op_reg != OP_WAIT) || report_ok)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = op_reg;
                        m_tdata_next  = {cnt_reg, ra_reg, mx_reg, cv_reg, th_reg};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            early_reg     <= EARLY_LIMIT_RST;
            shift_reg     <= SAMPLE_SHIFT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            early_reg     <= early_next;
            shift_reg     <= shift_next;
        end
    end

    // payload and scan bookkeeping registers
    always_ff @(posedge clk)
    begin
        issue_cnt_reg <= issue_cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        have_free_reg <= have_free_next;
        free_idx_reg  <= free_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        op_reg        <= op_next;
        th_reg        <= th_next;
        cv_reg        <= cv_next;
        mx_reg        <= mx_next;
        ra_reg        <= ra_next;
        cnt_reg       <= cnt_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

`default_nettype wire

// File: rtl/kwctf_ram.sv
// slot table memory: one write port, one registered read port
`default_nettype none

module kwctf_ram #(
    parameter int DEPTH = kwctf_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire kwctf_pkg::entry_t wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output kwctf_pkg::entry_t      rd_data
);
    import kwctf_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/kwctf_checker.sv
// port-level checks for the trace filter, bound to the top level
`default_nettype none

module kwctf_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [kwctf_pkg::TUSER_W-1:0]     s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [kwctf_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [kwctf_pkg::TUSER_W-1:0]     m_tuser
);
    import kwctf_pkg::*;

    // stalled report beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("report beat changed while stalled");

    // the other kind never appears on the output
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != OP_OTHER)
        else $error("report with other kind");

    // signal and broadcast carry mutex zero and count one
    a_non_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == OP_SIGNAL || m_tuser == OP_BROADCAST)
        |-> m_tdata[95:64] == '0 && m_tdata[159:128] == 32'd1)
        else $error("non-wait report with bad mutex or count");

    // an accepted event that needs work closes the input
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != OP_OTHER |=> !s_tready)
        else $error("input ready while an event is in work");

endmodule

bind keyed_wait_counter_trace_filter_unit kwctf_checker u_kwctf_checker (.*);

`default_nettype wire
